>>> src/blop_pkg.sv
package blop_pkg;

    // operation broadcast to every lattice cell
    typedef logic [2:0] cell_op_t;

    localparam cell_op_t OP_HOLD   = 3'd0;
    localparam cell_op_t OP_LOAD   = 3'd1;
    localparam cell_op_t OP_SCALE  = 3'd2;
    localparam cell_op_t OP_PAYOFF = 3'd3;
    localparam cell_op_t OP_MIX    = 3'd4;
    localparam cell_op_t OP_DISC   = 3'd5;

    // option kinds, any other code prices to zero
    localparam logic [1:0] KIND_CALL = 2'd0;
    localparam logic [1:0] KIND_PUT  = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_UP_FACTOR     = 3'd0;
    localparam logic [2:0] CFG_DOWN_FACTOR   = 3'd1;
    localparam logic [2:0] CFG_UP_PROB       = 3'd2;
    localparam logic [2:0] CFG_STEP_DISCOUNT = 3'd3;
    localparam logic [2:0] CFG_STEP_COUNT    = 3'd4;

    // configuration reset values
    localparam logic [31:0] UP_FACTOR_RST     = 32'h4000_0000;
    localparam logic [30:0] DOWN_FACTOR_RST   = 31'h4000_0000;
    localparam logic [31:0] UP_PROB_RST       = 32'h8000_0000;
    localparam logic [31:0] STEP_DISCOUNT_RST = 32'hFFFF_FFFF;
    localparam logic [6:0]  STEP_COUNT_RST    = 7'd64;

    // control and operands shared by all cells
    typedef struct packed {
        cell_op_t    op;
        logic [31:0] spot;
        logic [31:0] strike;
        logic [1:0]  kind;
        logic [31:0] up_factor;
        logic [30:0] down_factor;
        logic [31:0] up_probability;
        logic [31:0] step_discount;
    } cell_ctrl_t;

endpackage

>>> src/blop_cell.sv
module blop_cell (
    input  logic                clk,
    input  blop_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         nbr_val,
    input  logic                lo_flag,
    output logic [31:0]         val,
    output logic                flag
);
    import blop_pkg::*;

    logic [31:0]        val_reg;
    logic [31:0]        val_next;
    logic               flag_reg;
    logic               flag_next;
    logic [32:0]        diff;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod;
    logic [34:0]        mix_sum;

    // up minus down node, signed
    assign diff = {1'b0, val_reg} - {1'b0, nbr_val};

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.op)
            OP_MIX:
            begin
                mul_a = $signed({diff[32], diff});
                mul_b = $signed({1'b0, ctrl.up_probability});
            end
            OP_DISC:
            begin
                mul_a = $signed({2'b00, val_reg});
                mul_b = $signed({1'b0, ctrl.step_discount});
            end
            default:
            begin
                mul_a = $signed({2'b00, val_reg});
                mul_b = lo_flag ? $signed({2'b00, ctrl.down_factor})
                                : $signed({1'b0, ctrl.up_factor});
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // down + floor(p * (up - down) / 2^32)
    assign mix_sum = {3'b000, nbr_val} + prod[66:32];

    // next node value
    always_comb
    begin
        val_next  = val_reg;
        flag_next = flag_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                val_next  = ctrl.spot;
                flag_next = 1'b1;
            end
            OP_SCALE:
            begin
                val_next  = (prod[63:62] != 2'b00) ? 32'hFFFF_FFFF : prod[61:30];
                flag_next = lo_flag;
            end
            OP_PAYOFF:
            begin
                if (ctrl.kind == KIND_CALL)
                begin
                    val_next = (val_reg > ctrl.strike) ? val_reg - ctrl.strike : 32'd0;
                end
                else if (ctrl.kind == KIND_PUT)
                begin
                    val_next = (ctrl.strike > val_reg) ? ctrl.strike - val_reg : 32'd0;
                end
                else
                begin
                    val_next = 32'd0;
                end
            end
            OP_MIX:  val_next = mix_sum[31:0];
            OP_DISC: val_next = prod[63:32];
            default: val_next = val_reg;
        endcase
    end

    // node storage
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        flag_reg <= flag_next;
    end

    assign val  = val_reg;
    assign flag = flag_reg;

endmodule

>>> src/blop_lattice.sv
module blop_lattice #(
    parameter int CELLS = 65
) (
    input  logic                 clk,
    input  blop_pkg::cell_ctrl_t ctrl,
    output logic [31:0]          root_val
);
    import blop_pkg::*;

    logic [31:0] vals  [CELLS];
    logic        flags [CELLS];

    // row of cells, each reads its upper neighbor value and lower neighbor flag
    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            logic [31:0] nbr;
            logic        lo;
            if (g == CELLS - 1)
            begin : g_top
                assign nbr = 32'd0;
            end
            else
            begin : g_mid
                assign nbr = vals[g + 1];
            end
            if (g == 0)
            begin : g_bot
                assign lo = 1'b0;
            end
            else
            begin : g_up
                assign lo = flags[g - 1];
            end
            blop_cell u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .nbr_val (nbr),
                .lo_flag (lo),
                .val     (vals[g]),
                .flag    (flags[g])
            );
        end
    endgenerate

    assign root_val = vals[0];

endmodule

>>> src/binomial_lattice_option_pricer_unit.sv
// binomial lattice (cox-ross-rubinstein) pricer for european options
// input channel s_*: one word carries spot and strike in s_tdata and the
// option kind in s_tuser; output channel m_*: one word with the root value.
// configuration: cfg_wr_en/cfg_index/cfg_wdata write up factor, down factor,
// up probability, step discount and step count; write only while idle.
// a word is taken only when the block is idle. the lattice loads the spot
// at the accepting edge, then runs the leaf scaling steps, the payoff step,
// both halves of each backward level (mix, then discount) and the step
// into the output register. a new word is accepted once the sequencer is
// back in idle after that register load. the one multiplier in each lattice
// cell serves the leaf scaling and both halves of each fold level in turn.
// reset returns the registers to their defaults and clears the sequencer
// and output valid. a stalled receiver holds the result in the output
// register; the next item is still accepted and computed, and waits in the
// final state until the output register is free.
module binomial_lattice_option_pricer_unit #(
    parameter int MAX_STEPS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // spot_price[31:0], strike_price[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // option_value[31:0]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import blop_pkg::*;

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int SW = (CW > 7) ? CW : 7;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEAF = 3'd1;
    localparam logic [2:0] ST_PAY  = 3'd2;
    localparam logic [2:0] ST_FA   = 3'd3;
    localparam logic [2:0] ST_FB   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [31:0]   up_reg;
    logic [30:0]   down_reg;
    logic [31:0]   prob_reg;
    logic [31:0]   disc_reg;
    logic [6:0]    steps_reg;
    logic [31:0]   strike_reg;
    logic [1:0]    kind_reg;
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [31:0]   m_data_reg;
    logic [SW-1:0] steps_ext;
    logic [SW-1:0] n_sel;
    logic [CW-1:0] n_eff;
    logic          accept;
    logic          out_free;
    cell_op_t      op_sel;
    cell_ctrl_t    ctrl;
    logic [31:0]   root_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg    <= UP_FACTOR_RST;
            down_reg  <= DOWN_FACTOR_RST;
            prob_reg  <= UP_PROB_RST;
            disc_reg  <= STEP_DISCOUNT_RST;
            steps_reg <= STEP_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_UP_FACTOR:     up_reg    <= cfg_wdata;
                CFG_DOWN_FACTOR:   down_reg  <= cfg_wdata[30:0];
                CFG_UP_PROB:       prob_reg  <= cfg_wdata;
                CFG_STEP_DISCOUNT: disc_reg  <= cfg_wdata;
                CFG_STEP_COUNT:    steps_reg <= cfg_wdata[6:0];
                default:           ;
            endcase
        end
    end

    // step count clamped to 1..MAX_STEPS
    assign steps_ext = SW'(steps_reg);
    always_comb
    begin
        if (steps_ext == '0)
        begin
            n_sel = SW'(1);
        end
        else if (steps_ext > SW'(MAX_STEPS))
        begin
            n_sel = SW'(MAX_STEPS);
        end
        else
        begin
            n_sel = steps_ext;
        end
    end
    assign n_eff = n_sel[CW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_sel     = OP_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_sel     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                op_sel   = OP_SCALE;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == n_eff - 1'b1)
                begin
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                op_sel     = OP_PAYOFF;
                cnt_next   = n_eff;
                state_next = ST_FA;
            end
            ST_FA:
            begin
                op_sel     = OP_MIX;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                op_sel     = OP_DISC;
                cnt_next   = cnt_reg - 1'b1;
                state_next = (cnt_reg == CW'(1)) ? ST_OUT : ST_FA;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operands broadcast to the lattice
    assign ctrl.op             = op_sel;
    assign ctrl.spot           = s_tdata[31:0];
    assign ctrl.strike         = strike_reg;
    assign ctrl.kind           = kind_reg;
    assign ctrl.up_factor      = up_reg;
    assign ctrl.down_factor    = down_reg;
    assign ctrl.up_probability = prob_reg;
    assign ctrl.step_discount  = disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // strike and kind held for the payoff cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            strike_reg <= s_tdata[63:32];
            kind_reg   <= s_tuser;
        end
    end

    blop_lattice #(
        .CELLS (MAX_STEPS + 1)
    ) u_lattice (
        .clk      (clk),
        .ctrl     (ctrl),
        .root_val (root_val)
    );

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            m_data_reg <= root_val;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // accepted word starts the leaf build from step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LEAF) && (cnt_reg == '0))
        else $error("leaf build did not start after accept");

    // leaf step counter stays below the step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEAF) |-> (cnt_reg < n_eff))
        else $error("leaf step counter out of range");

    // fold levels remaining is never zero while folding
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FA || state_reg == ST_FB) |-> (cnt_reg != '0))
        else $error("fold level counter reached zero while folding");

    // last fold level hands the root to the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FB && cnt_reg == CW'(1)) |=> (state_reg == ST_OUT))
        else $error("last fold level did not reach output stage");

    // a finished result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("result left output stage while output register busy");

endmodule

>>> tb/tb_binomial_lattice_option_pricer_unit.sv
`timescale 1ns / 1ps

module tb_binomial_lattice_option_pricer_unit;

    import blop_pkg::*;

    localparam int          LATTICE_MAX = 64;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          RANDOM_ITEMS = 1350;
    localparam logic [1:0]  KIND_NONE  = 2'd2;
    localparam logic [1:0]  KIND_SPARE = 2'd3;
    localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
    localparam logic [31:0] Q16_MAX    = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] spot;
        logic [31:0] strike;
        logic [1:0]  kind;
    } option_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = 64'd0;   // spot_price[31:0], strike_price[63:32]
    logic [1:0]  s_tuser = 2'd0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // option_value[31:0]
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_wdata = 32'd0;

    // local copy of the pricing registers
    logic [31:0] lat_up     = UP_FACTOR_RST;
    logic [30:0] lat_down   = DOWN_FACTOR_RST;
    logic [31:0] lat_prob   = UP_PROB_RST;
    logic [31:0] lat_disc   = STEP_DISCOUNT_RST;
    logic [6:0]  lat_steps  = STEP_COUNT_RST;

    option_word_t pending_words[$];
    logic [31:0]  expected_values[$];
    option_word_t cur_word = '{32'd0, 32'd0, 2'd0};

    int sent_cnt = 0;
    int taken_cnt = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_left = 0;
    int rx_mode = 0;
    int rx_stall = 0;
    int queued_total = 0;

    binomial_lattice_option_pricer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    // q2.30 multiply, truncated and saturated
    function automatic logic [31:0] scale_q30(logic [31:0] x, logic [31:0] f);
        logic [63:0] prod;
        prod = ({32'd0, x} * {32'd0, f}) >> 30;
        return (prod > {32'd0, Q16_MAX}) ? Q16_MAX : prod[31:0];
    endfunction

    // one backward step: weighted mix of up and down nodes, then discount
    function automatic logic [31:0] fold_pair(logic [31:0] up_v, logic [31:0] dn_v);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] mix;
        logic [63:0] disc;
        p = {32'd0, lat_prob};
        sum = ({32'd0, dn_v} << 32) + p * {32'd0, up_v} - p * {32'd0, dn_v};
        mix = sum >> 32;
        disc = mix * {32'd0, lat_disc};
        return disc[63:32];
    endfunction

    // full lattice: leaves, payoffs, backward induction to the root
    function automatic logic [31:0] crr_price(logic [31:0] spot, logic [31:0] strike,
                                              logic [1:0] kind);
        logic [31:0] nodes [0:LATTICE_MAX];
        logic [31:0] x;
        int n;
        int i;
        int j;
        int k;
        n = lat_steps;
        if (n < 1) n = 1;
        if (n > LATTICE_MAX) n = LATTICE_MAX;
        for (j = 0; j <= n; j++)
        begin
            x = spot;
            for (k = 0; k < j; k++) x = scale_q30(x, {1'b0, lat_down});
            for (k = j; k < n; k++) x = scale_q30(x, lat_up);
            case (kind)
                KIND_CALL: nodes[j] = (x > strike) ? x - strike : 32'd0;
                KIND_PUT:  nodes[j] = (strike > x) ? strike - x : 32'd0;
                default:   nodes[j] = 32'd0;
            endcase
        end
        for (i = n; i > 0; i--)
        begin
            for (j = 0; j < i; j++) nodes[j] = fold_pair(nodes[j], nodes[j + 1]);
        end
        return nodes[0];
    endfunction

    // sender: bursts of words with random gaps, noise on the bus while idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (sent_cnt == taken_cnt)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    sent_cnt++;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 220)
                                                               : $urandom_range(0, 4);
                    end
                end
            end
            if (sent_cnt != taken_cnt)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_word.strike, cur_word.spot};
                s_tuser  <= cur_word.kind;
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom, $urandom};
                s_tuser  <= 2'($urandom);
            end
        end
    end

    // receiver: its own stall pattern, switching between four modes at random
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((rx_left % 5) < 2);
            default:
            begin
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_stall = $urandom_range(1, 60);
                end
            end
        endcase
    end

    // accepted input word: price it now, config is stable while busy
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_values.push_back(crr_price(s_tdata[31:0], s_tdata[63:32], s_tuser));
            taken_cnt++;
        end
    end

    // accepted output word: compare with the oldest expected value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("ERROR: unexpected output word option_value=%h", m_tdata);
            end
            else
            begin
                logic [31:0] want;
                want = expected_values.pop_front();
                if (m_tdata !== want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: option_value expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_UP_FACTOR:     lat_up = val;
            CFG_DOWN_FACTOR:   lat_down = val[30:0];
            CFG_UP_PROB:       lat_prob = val;
            CFG_STEP_DISCOUNT: lat_disc = val;
            CFG_STEP_COUNT:    lat_steps = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_lattice(logic [31:0] u, logic [31:0] d, logic [31:0] p,
                               logic [31:0] disc, logic [31:0] steps);
        cfg_write(CFG_UP_FACTOR, u);
        cfg_write(CFG_DOWN_FACTOR, d);
        cfg_write(CFG_UP_PROB, p);
        cfg_write(CFG_STEP_DISCOUNT, disc);
        cfg_write(CFG_STEP_COUNT, steps);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_word(logic [31:0] spot, logic [31:0] strike, logic [1:0] kind);
        pending_words.push_back('{spot, strike, kind});
        queued_total++;
    endtask

    // wait until every queued word went in and every result came out
    task automatic wait_drained;
        while (pending_words.size() != 0 || sent_cnt != taken_cnt ||
               expected_values.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] u;
        logic [31:0] d;
        logic [31:0] p;
        logic [31:0] disc;
        logic [31:0] steps;
        logic [31:0] spot;
        logic [31:0] strike;
        logic [1:0]  kind;
        int sel;
        int count;
        int idx;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: flat lattice, 64 steps, price extremes and all kinds
        add_word(Q16_MAX, 32'd0, KIND_CALL);
        add_word(32'd0, Q16_MAX, KIND_PUT);
        add_word($urandom, $urandom, KIND_NONE);
        add_word($urandom, $urandom, KIND_SPARE);
        wait_drained();

        // realistic factors, step count zero runs as one step; unused indexes ignored
        for (idx = CFG_STEP_COUNT + 1; idx < 8; idx++) cfg_write(3'(idx), $urandom);
        set_lattice(32'h4CCC_CCCD, 32'h3555_5555, 32'h7C00_0000, 32'hFFF0_0000,
                    32'hFFFF_FF80);
        add_word(32'h0064_0000, 32'h0060_0000, KIND_CALL);
        add_word(32'h0064_0000, 32'h0070_0000, KIND_PUT);
        add_word(Q16_MAX, 32'h0000_0001, KIND_CALL);
        wait_drained();

        // step count above the maximum runs as the maximum
        set_lattice(32'h4CCC_CCCD, 32'h3555_5555, 32'h7C00_0000, 32'hFFF0_0000, 32'd127);
        add_word(32'h0064_0000, 32'h0064_0000, KIND_CALL);
        add_word(32'h0064_0000, 32'h0064_0000, KIND_PUT);
        add_word(32'h0000_0001, Q16_MAX, KIND_PUT);
        wait_drained();

        // extremes: largest up factor, zero down, zero probability and discount
        set_lattice(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd64);
        add_word(32'h0000_0001, 32'd0, KIND_CALL);
        add_word(Q16_MAX, Q16_MAX, KIND_PUT);
        wait_drained();

        // down factor above its range with top bit stray, full probability
        set_lattice(Q30_ONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5601);
        add_word($urandom, $urandom, KIND_CALL);
        add_word($urandom, $urandom, KIND_PUT);
        add_word(Q16_MAX, 32'd0, KIND_CALL);
        wait_drained();

        // random phases, each under its own lattice setting
        while (queued_total < RANDOM_ITEMS)
        begin
            u = ($urandom_range(0, 4) == 0) ? ($urandom | Q30_ONE)
                                            : Q30_ONE + $urandom_range(0, 32'h1000_0000);
            sel = $urandom_range(0, 7);
            if (sel == 0)      d = $urandom & 32'h7FFF_FFFF;
            else if (sel < 3)  d = $urandom_range(0, Q30_ONE);
            else               d = Q30_ONE - $urandom_range(0, 32'h1000_0000);
            d = d | ($urandom & 32'h8000_0000);
            p = $urandom;
            disc = ($urandom_range(0, 3) == 0) ? $urandom
                                               : Q16_MAX - $urandom_range(0, 32'h0100_0000);
            sel = $urandom_range(0, 15);
            if (sel == 0)      steps = 0;
            else if (sel == 1) steps = $urandom_range(65, 127);
            else if (sel < 5)  steps = $urandom_range(33, 64);
            else               steps = $urandom_range(1, 16);
            steps = steps | ($urandom & 32'hFFFF_FF80);
            set_lattice(u, d, p, disc, steps);

            count = $urandom_range(10, 60);
            repeat (count)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    spot = $urandom;
                    strike = $urandom;
                end
                else
                begin
                    spot = $urandom_range(0, 32'h00FF_FFFF);
                    strike = ($urandom_range(0, 1) == 0) ? spot + $urandom_range(0, 32'h0040_0000)
                                                         : spot - $urandom_range(0, spot);
                end
                sel = $urandom_range(0, 9);
                if (sel < 4)      kind = KIND_CALL;
                else if (sel < 8) kind = KIND_PUT;
                else if (sel < 9) kind = KIND_NONE;
                else              kind = KIND_SPARE;
                add_word(spot, strike, kind);
            end
            wait_drained();
        end

        // tail: room for any stray output word
        repeat (3 * LATTICE_MAX + 20) @(posedge clk);
        if (err_cnt == 0 && expected_values.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/blop_pkg.sv
src/blop_cell.sv
src/blop_lattice.sv
src/binomial_lattice_option_pricer_unit.sv
tb/tb_binomial_lattice_option_pricer_unit.sv
